@@ src/crth_pkg.sv @@
// Shared types and constants for the closest ray/triangle hit block.
`timescale 1ns / 1ps

package crth_pkg;

   // Internal coordinate: a 16-bit field, sign- or zero-extended.
   localparam int CW = 17;
   // Widths of the arithmetic datapath.
   localparam int NW    = 18;  // coordinate difference
   localparam int CR_W  = 36;  // cross product component / wide multiplier operand
   localparam int MB_W  = 19;  // narrow multiplier operand
   localparam int PR_W  = 55;  // product
   localparam int DET_W = 58;  // determinant and divider operand
   localparam int T_W   = 32;  // Q16.16 ray parameter
   localparam int PT_W  = 18;  // hit point coordinate

   // Width of the packed channel payloads.
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 112;

   // Mode codes carried on the request tuser.
   localparam logic [1:0] MODE_RAY = 2'd0;
   localparam logic [1:0] MODE_BOX = 2'd1;
   localparam logic [1:0] MODE_TRI = 2'd2;

   typedef logic signed [CW-1:0] coord_type;

   typedef enum logic [1:0] {
      KIND_RAY,
      KIND_BOX,
      KIND_TRI,
      KIND_NONE
   } kind_type;

   // One classified item as it sits in the queue.
   typedef struct packed {
      kind_type              kind;
      coord_type [2:0]       a;
      coord_type [2:0]       b;
      coord_type [2:0]       c;
      logic [15:0]           face;
      logic                  last;
   } item_type;

endpackage

@@ src/crth_front.sv @@
// Front end: accepts request transfers, classifies them and queues them.
`timescale 1ns / 1ps

module crth_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, face_number (lowest first)
   input  logic [crth_pkg::REQ_DATA_W-1:0]      req_tdata,
   // mode
   input  logic [1:0]                           req_tuser,
   input  logic                                 req_tlast,
   output logic                                 q_valid,
   output crth_pkg::item_type                   q_item,
   input  logic                                 q_pop
);
   import crth_pkg::*;

   localparam int SH = (COORD_BITS >= 16) ? 0 : 16 - COORD_BITS;

   // Keep the low COORD_BITS bits of a field and sign-extend them.
   function automatic coord_type to_coord(input logic [15:0] f);
      logic [15:0] sh;
      sh = f << SH;
      if (COORD_BITS > 16) begin
         return {1'b0, f};
      end
      return CW'($signed(sh) >>> SH);
   endfunction

   item_type  new_item;
   item_type  q_ff [2];
   logic      wr_ff;
   logic      rd_ff;
   logic [1:0] cnt_ff;
   logic      push;
   logic      pop;

   // Classify the incoming transfer
   always_comb begin
      new_item = '0;
      unique case (req_tuser)
         MODE_RAY: new_item.kind = KIND_RAY;
         MODE_BOX: new_item.kind = KIND_BOX;
         MODE_TRI: new_item.kind = KIND_TRI;
         default:  new_item.kind = KIND_NONE;
      endcase
      for (int k = 0; k < 3; k++) begin
         new_item.a[k] = to_coord(req_tdata[16*k +: 16]);
         new_item.b[k] = to_coord(req_tdata[48 + 16*k +: 16]);
         new_item.c[k] = to_coord(req_tdata[96 + 16*k +: 16]);
      end
      new_item.face = req_tdata[159:144];
      new_item.last = req_tlast;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign pop        = q_pop & q_valid;
   assign q_item     = q_ff[rd_ff];

   // Two-entry queue between front and back
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_ff ^ push;
         rd_ff  <= rd_ff ^ pop;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

@@ src/crth_div.sv @@
// Serial restoring divider giving a saturated Q16.16 quotient.
`timescale 1ns / 1ps

module crth_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [crth_pkg::DET_W-1:0]      num,
   input  logic signed [crth_pkg::DET_W-1:0]      den,
   output logic                                   done,
   output logic signed [crth_pkg::T_W-1:0]        quo
);
   import crth_pkg::*;

   localparam int STEPS = T_W;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [DET_W-1:0]  un_in;
   logic [DET_W-1:0]  ud_in;
   logic              sat_in;
   logic [DET_W-1:0]  ud_ff;
   logic [DET_W:0]    rem_ff;
   logic [T_W-1:0]    low_ff;
   logic [T_W-1:0]    q_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              neg_ff;
   logic              sat_ff;
   logic              done_ff;
   logic [DET_W:0]    r2;
   logic              ge;
   logic [T_W:0]      mag;

   // Magnitudes and early saturation check
   always_comb begin
      un_in  = num[DET_W-1] ? DET_W'(-num) : DET_W'(num);
      ud_in  = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
      sat_in = {16'd0, un_in} >= {ud_in, 16'd0};
      r2     = {rem_ff[DET_W-1:0], low_ff[T_W-1]};
      ge     = r2 >= {1'b0, ud_ff};
   end

   // One quotient bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            ud_ff  <= ud_in;
            neg_ff <= num[DET_W-1] ^ den[DET_W-1];
            sat_ff <= sat_in;
            q_ff   <= '0;
            rem_ff <= (DET_W+1)'(un_in >> 16);
            low_ff <= {un_in[15:0], 16'd0};
            if (sat_in) begin
               cnt_ff  <= '0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= CNT_W'(STEPS);
            end
         end else if (cnt_ff != '0) begin
            rem_ff <= ge ? r2 - {1'b0, ud_ff} : r2;
            q_ff   <= {q_ff[T_W-2:0], ge};
            low_ff <= low_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Apply sign and saturate to the Q16.16 range
   always_comb begin
      mag = sat_ff ? {1'b1, {T_W{1'b0}}} : {1'b0, q_ff};
      if (neg_ff) begin
         quo = (mag > {2'b01, {(T_W-1){1'b0}}}) ? {1'b1, {(T_W-1){1'b0}}} : T_W'(-mag);
      end else begin
         quo = (mag > {2'b00, {(T_W-1){1'b1}}}) ? {1'b0, {(T_W-1){1'b1}}} : mag[T_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

@@ src/crth_back.sv @@
// Back end: ray state, slab test, determinant sequencer and best-hit keeping.
`timescale 1ns / 1ps

module crth_back #(
   parameter int MAX_MESHES = 256,
   parameter int FACE_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  crth_pkg::item_type                   q_item,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [crth_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tuser
);
   import crth_pkg::*;

   localparam logic [15:0] FACE_MASK =
      (FACE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << FACE_BITS) - 32'd1);
   localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
   localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
   localparam logic signed [PR_W:0] PT_MAX = (PR_W+1)'(131071);
   localparam logic signed [PR_W:0] PT_MIN = -(PR_W+1)'(131072);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLAB,
      ST_SLAB_WAIT,
      ST_SLAB_GOT,
      ST_BOX_END,
      ST_MAC,
      ST_DRAIN,
      ST_NORM,
      ST_TEST,
      ST_TDIV,
      ST_BEST,
      ST_POINT,
      ST_POINT_WR,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   item_type                 it_ff;
   coord_type                org_ff [3];
   coord_type                dir_ff [3];
   logic signed [NW-1:0]     n_ff [3];
   logic signed [CR_W-1:0]   cr_ff [9];
   logic signed [DET_W-1:0]  det_ff [4];
   logic signed [DET_W-1:0]  acc_ff;
   logic signed [PR_W-1:0]   prod_ff;
   logic                     pend_ff;
   logic                     pneg_ff;
   logic                     pfirst_ff;
   logic                     pstore_ff;
   logic [3:0]               pdst_ff;
   logic                     dot_ff;
   logic [1:0]               vsel_ff;
   logic [1:0]               comp_ff;
   logic                     term_ff;
   logic [1:0]               axis_ff;
   logic                     hi_sel_ff;
   logic signed [T_W-1:0]    slab_ff;
   logic signed [T_W-1:0]    ta_ff;
   logic signed [T_W-1:0]    tmin_ff;
   logic signed [T_W-1:0]    tmax_ff;
   logic [7:0]               mesh_ctr_ff;
   logic                     skipped_ff;
   logic                     have_hit_ff;
   logic signed [T_W-1:0]    best_t_ff;
   logic [15:0]              best_face_ff;
   logic [7:0]               best_mesh_ff;
   logic signed [PT_W-1:0]   best_pt_ff [3];
   logic signed [T_W-1:0]    t_ff;
   logic [1:0]               pt_idx_ff;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic                     rsp_user_ff;

   // Multiplier operands and sequencer control for the current cycle
   logic signed [CR_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PR_W-1:0]   prod_in;
   logic                     op_neg;
   logic                     op_first;
   logic                     op_store;
   logic [3:0]               op_dst;
   coord_type                va [3];
   coord_type                vb [3];
   logic [1:0]               i1;
   logic [1:0]               i2;
   logic [3:0]               cr_sel;
   logic signed [DET_W-1:0]  pterm;
   logic signed [DET_W-1:0]  acc_in;
   logic signed [NW-1:0]     snum;
   logic                     tri_fail;
   logic signed [T_W-1:0]    nr;
   logic signed [T_W-1:0]    fr;
   logic [8:0]               mesh_nx;
   logic [7:0]               mesh_in;
   logic signed [PR_W-1:0]   pt_q;
   logic signed [PR_W:0]     pt_sum;
   logic signed [PT_W-1:0]   pt_in;
   logic                     div_start;
   logic signed [DET_W-1:0]  div_num;
   logic signed [DET_W-1:0]  div_den;
   logic                     div_done;
   logic signed [T_W-1:0]    div_quo;
   logic                     emit;

   crth_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Select the operand pair of the running multiply
   always_comb begin
      unique case (comp_ff)
         2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
         2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
         default: begin i1 = 2'd0; i2 = 2'd1; end
      endcase
      unique case (vsel_ff)
         2'd0: begin
            for (int k = 0; k < 3; k++) begin va[k] = it_ff.c[k]; vb[k] = dir_ff[k]; end
         end
         2'd1: begin
            for (int k = 0; k < 3; k++) begin va[k] = dir_ff[k]; vb[k] = it_ff.b[k]; end
         end
         default: begin
            for (int k = 0; k < 3; k++) begin va[k] = it_ff.b[k]; vb[k] = it_ff.c[k]; end
         end
      endcase
      unique case (vsel_ff)
         2'd0, 2'd1: cr_sel = 4'd0;
         2'd2:       cr_sel = 4'd3;
         default:    cr_sel = 4'd6;
      endcase
      mul_a    = '0;
      mul_b    = '0;
      op_neg   = 1'b0;
      op_first = 1'b0;
      op_store = 1'b0;
      op_dst   = '0;
      if (state_ff == ST_POINT) begin
         mul_a = CR_W'(t_ff);
         mul_b = MB_W'(dir_ff[pt_idx_ff]);
      end else if (state_ff == ST_MAC && !dot_ff) begin
         mul_a    = term_ff ? CR_W'($signed(va[i2])) : CR_W'($signed(va[i1]));
         mul_b    = term_ff ? MB_W'($signed(vb[i1])) : MB_W'($signed(vb[i2]));
         op_neg   = term_ff;
         op_first = !term_ff;
         op_store = term_ff;
         op_dst   = 4'(vsel_ff) * 4'd3 + 4'(comp_ff);
      end else if (state_ff == ST_MAC) begin
         mul_a    = cr_ff[cr_sel + 4'(comp_ff)];
         mul_b    = (vsel_ff == 2'd0) ? MB_W'($signed(it_ff.b[comp_ff]))
                                      : MB_W'(n_ff[comp_ff]);
         op_first = (comp_ff == 2'd0);
         op_store = (comp_ff == 2'd2);
         op_dst   = 4'd9 + 4'(vsel_ff);
      end
      prod_in = mul_a * mul_b;
   end

   // Accumulate, slab, triangle test and hit point arithmetic
   always_comb begin
      pterm   = DET_W'(prod_ff);
      if (pneg_ff) begin
         pterm = -pterm;
      end
      acc_in  = (pfirst_ff ? '0 : acc_ff) + pterm;
      snum    = (hi_sel_ff ? NW'(it_ff.b[axis_ff]) : NW'(it_ff.a[axis_ff]))
              - NW'(org_ff[axis_ff]);
      tri_fail = (det_ff[1] <= 0) || (det_ff[2] <= 0)
              || ((DET_W+1)'(det_ff[1]) + (DET_W+1)'(det_ff[2]) >= (DET_W+1)'(det_ff[0]));
      nr      = (ta_ff < slab_ff) ? ta_ff : slab_ff;
      fr      = (ta_ff < slab_ff) ? slab_ff : ta_ff;
      mesh_nx = {1'b0, mesh_ctr_ff} + 9'd1;
      mesh_in = (32'(mesh_nx) >= 32'(MAX_MESHES)) ? 8'd0 : mesh_nx[7:0];
      pt_q    = (prod_ff + (prod_ff[PR_W-1] ? PR_W'(65535) : PR_W'(0))) >>> 16;
      pt_sum  = (PR_W+1)'(pt_q) + (PR_W+1)'(org_ff[pt_idx_ff]);
      if (pt_sum > PT_MAX) begin
         pt_in = PT_W'(PT_MAX);
      end else if (pt_sum < PT_MIN) begin
         pt_in = PT_W'(PT_MIN);
      end else begin
         pt_in = PT_W'(pt_sum);
      end
      div_start = (state_ff == ST_TEST && det_ff[0] != 0 && !tri_fail)
               || (state_ff == ST_SLAB && dir_ff[axis_ff] != 0);
      div_num   = (state_ff == ST_TEST) ? det_ff[3] : DET_W'(snum);
      div_den   = (state_ff == ST_TEST) ? det_ff[0] : DET_W'(dir_ff[axis_ff]);
      // Load the output register once it is free or being drained
      emit      = (state_ff == ST_FINISH) && it_ff.last && (!rsp_valid_ff || rsp_tready);
   end

   assign q_pop = (state_ff == ST_IDLE);

   // Sequencer, ray state and best hit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         mesh_ctr_ff  <= 8'hFF;
         skipped_ff   <= 1'b0;
         have_hit_ff  <= 1'b0;
         best_t_ff    <= '0;
         best_face_ff <= '0;
         best_mesh_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            org_ff[k]     <= '0;
            dir_ff[k]     <= '0;
            best_pt_ff[k] <= '0;
         end
      end else begin
         // Multiply pipeline: product now, accumulate next cycle
         prod_ff   <= prod_in;
         pend_ff   <= (state_ff == ST_MAC);
         pneg_ff   <= op_neg;
         pfirst_ff <= op_first;
         pstore_ff <= op_store;
         pdst_ff   <= op_dst;
         if (pend_ff) begin
            acc_ff <= acc_in;
            if (pstore_ff) begin
               if (pdst_ff < 4'd9) begin
                  cr_ff[pdst_ff] <= CR_W'(acc_in);
               end else begin
                  det_ff[2'(pdst_ff - 4'd9)] <= acc_in;
               end
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  it_ff <= q_item;
                  unique case (q_item.kind)
                     KIND_RAY: begin
                        for (int k = 0; k < 3; k++) begin
                           org_ff[k]     <= q_item.a[k];
                           dir_ff[k]     <= q_item.b[k];
                           best_pt_ff[k] <= '0;
                        end
                        skipped_ff   <= 1'b0;
                        mesh_ctr_ff  <= 8'hFF;
                        have_hit_ff  <= 1'b0;
                        best_t_ff    <= '0;
                        best_face_ff <= '0;
                        best_mesh_ff <= '0;
                        state_ff     <= ST_FINISH;
                     end
                     KIND_BOX: begin
                        mesh_ctr_ff <= mesh_in;
                        axis_ff     <= 2'd0;
                        hi_sel_ff   <= 1'b0;
                        state_ff    <= ST_SLAB;
                     end
                     KIND_TRI: begin
                        for (int k = 0; k < 3; k++) begin
                           n_ff[k] <= NW'(q_item.a[k]) - NW'(org_ff[k]);
                        end
                        dot_ff   <= 1'b0;
                        vsel_ff  <= 2'd0;
                        comp_ff  <= 2'd0;
                        term_ff  <= 1'b0;
                        state_ff <= skipped_ff ? ST_FINISH : ST_MAC;
                     end
                     default: state_ff <= ST_FINISH;
                  endcase
               end
            end
            ST_SLAB: begin
               if (dir_ff[axis_ff] == 0) begin
                  slab_ff  <= snum[NW-1] ? T_MIN : T_MAX;
                  state_ff <= ST_SLAB_GOT;
               end else begin
                  state_ff <= ST_SLAB_WAIT;
               end
            end
            ST_SLAB_WAIT: begin
               if (div_done) begin
                  slab_ff  <= div_quo;
                  state_ff <= ST_SLAB_GOT;
               end
            end
            ST_SLAB_GOT: begin
               if (!hi_sel_ff) begin
                  ta_ff     <= slab_ff;
                  hi_sel_ff <= 1'b1;
                  state_ff  <= ST_SLAB;
               end else begin
                  if (axis_ff == 2'd0 || nr > tmin_ff) begin
                     tmin_ff <= nr;
                  end
                  if (axis_ff == 2'd0 || fr < tmax_ff) begin
                     tmax_ff <= fr;
                  end
                  hi_sel_ff <= 1'b0;
                  axis_ff   <= axis_ff + 2'd1;
                  state_ff  <= (axis_ff == 2'd2) ? ST_BOX_END : ST_SLAB;
               end
            end
            ST_BOX_END: begin
               skipped_ff <= !(tmax_ff < 0 || tmin_ff <= tmax_ff);
               state_ff   <= ST_FINISH;
            end
            ST_MAC: begin
               // Cross products first, then the four dot products
               if (!dot_ff) begin
                  term_ff <= !term_ff;
                  if (term_ff) begin
                     comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
                     if (comp_ff == 2'd2) begin
                        vsel_ff <= (vsel_ff == 2'd2) ? 2'd0 : vsel_ff + 2'd1;
                        dot_ff  <= (vsel_ff == 2'd2);
                     end
                  end
               end else begin
                  comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
                  if (comp_ff == 2'd2) begin
                     vsel_ff <= vsel_ff + 2'd1;
                     if (vsel_ff == 2'd3) begin
                        state_ff <= ST_DRAIN;
                     end
                  end
               end
            end
            ST_DRAIN: state_ff <= ST_NORM;
            ST_NORM: begin
               if (det_ff[0] == 0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  if (det_ff[0] < 0) begin
                     for (int k = 0; k < 4; k++) begin
                        det_ff[k] <= -det_ff[k];
                     end
                  end
                  state_ff <= ST_TEST;
               end
            end
            ST_TEST: state_ff <= tri_fail ? ST_FINISH : ST_TDIV;
            ST_TDIV: begin
               if (div_done) begin
                  t_ff     <= div_quo;
                  state_ff <= ST_BEST;
               end
            end
            ST_BEST: begin
               if (have_hit_ff && !(t_ff < best_t_ff)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  have_hit_ff  <= 1'b1;
                  best_t_ff    <= t_ff;
                  best_face_ff <= it_ff.face & FACE_MASK;
                  best_mesh_ff <= mesh_ctr_ff;
                  pt_idx_ff    <= 2'd0;
                  state_ff     <= ST_POINT;
               end
            end
            ST_POINT: state_ff <= ST_POINT_WR;
            ST_POINT_WR: begin
               best_pt_ff[pt_idx_ff] <= pt_in;
               pt_idx_ff <= pt_idx_ff + 2'd1;
               state_ff  <= (pt_idx_ff == 2'd2) ? ST_FINISH : ST_POINT;
            end
            ST_FINISH: begin
               if (!it_ff.last) begin
                  state_ff <= ST_IDLE;
               end else if (emit) begin
                  rsp_user_ff  <= have_hit_ff;
                  rsp_data_ff  <= {2'b00, best_pt_ff[2], best_pt_ff[1], best_pt_ff[0],
                                   best_mesh_ff, best_face_ff, best_t_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");

   a_no_hit_is_clear: assert property (@(posedge clock) disable iff (reset)
      !have_hit_ff |-> (best_t_ff == 0 && best_face_ff == 0 && best_mesh_ff == 0))
      else $error("best hit fields set without a hit");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_TDIV || state_ff == ST_SLAB_WAIT))
      else $error("divider finished while nobody waits for it");
`endif

endmodule

@@ src/closest_ray_triangle_hit.sv @@
// Top level of the nearest ray/triangle hit finder.
//
// Request channel (req_*): one transfer per item. tuser carries the mode (ray, mesh box,
// triangle), tdata the three vectors and the face number, tlast marks the final item of
// a ray. A ray item loads origin and direction and clears the best hit; a box item opens
// the next mesh and runs the slab test; a triangle item is solved with 3x3 determinants.
// Result channel (rsp_*): one transfer after each item marked tlast, with tuser = hit
// found and tdata = t, face, mesh and hit point of the nearest hit.
// Items pass a two-entry queue to a sequencer that works on one item at a time.
// A box item takes up to six slab divisions on the serial divider (a division ends early
// when the quotient saturates and is skipped when an axis direction is zero); a triangle
// item takes 30 multiply steps on the one shared multiplier, a divider run for t and, on a
// new best hit, one multiply per hit point coordinate.
// The result sits in an output register; while the receiver stalls the sequencer holds
// at the next emitting item and the queue fills up to its two entries.
// Synchronous reset empties the queue, zeroes the ray and best hit and sets the mesh
// counter so that the next box is mesh 0.
`timescale 1ns / 1ps

module closest_ray_triangle_hit #(
   parameter int MAX_MESHES = 256,
   parameter int COORD_BITS = 16,
   parameter int FACE_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, vec_c_x, vec_c_y, vec_c_z,
   // face_number (lowest first)
   input  logic [crth_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // t_of_hit, hit_face, mesh_number, hit_x, hit_y, hit_z, two zero bits (lowest first)
   output logic [crth_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // hit_found
   output logic                               rsp_tuser
);
   import crth_pkg::*;

   logic      q_valid;
   item_type  q_item;
   logic      q_pop;

   crth_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   crth_back #(
      .MAX_MESHES (MAX_MESHES),
      .FACE_BITS  (FACE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
